@@ sv/mf3_pkg.sv @@
// Shared types, constants and comparator functions for the 3x3 median filter.
// No dependencies; every other file of the block imports this package.
package mf3_pkg;

	localparam int PIX_W = 8;
	localparam int POS_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int RESET_WIDTH = 720;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_SIZE = 3;
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t lo;
		pix_t mid;
		pix_t hi;
	} column_t;

	typedef struct packed {
		pix_t             median_value;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             last_of_frame;
	} result_t;

	function automatic pix_t pix_min(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pix_max(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t pix_mid3(input pix_t a, input pix_t b, input pix_t c);
		return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
	endfunction

	function automatic column_t sort3(input pix_t a, input pix_t b, input pix_t c);
		column_t s;
		s.lo  = pix_min(a, pix_min(b, c));
		s.mid = pix_mid3(a, b, c);
		s.hi  = pix_max(a, pix_max(b, c));
		return s;
	endfunction

	function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] maxv);
		logic [31:0] r;
		if (v < 32'(MIN_SIZE)) begin
			r = 32'(MIN_SIZE);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/mf3_if.sv @@
// Handshake interfaces for the pixel input and the median result output.
// Depends on mf3_pkg for the payload widths.
interface mf3_pix_if import mf3_pkg::*;;
	logic       valid;
	logic       ready;
	pix_t       pixel;
	logic       frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf3_res_if import mf3_pkg::*;;
	logic             valid;
	logic             ready;
	pix_t             median_value;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic             last_of_frame;

	modport source (output valid, output median_value, output out_row, output out_col,
		output last_of_frame, input ready);
	modport sink (input valid, input median_value, input out_row, input out_col,
		input last_of_frame, output ready);
endinterface

@@ sv/mf3_line_mem.sv @@
// Line store memory: one write port and one read port with registered read data.
// Each entry holds the pixel two rows above and the pixel one row above; uses mf3_pkg.
module mf3_line_mem import mf3_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [2*PIX_W-1:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [2*PIX_W-1:0]       rdata
);

	logic [2*PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/mf3_res_fifo.sv @@
// Small result queue that decouples the filter pipeline from the output receiver.
// Uses result_t from mf3_pkg.
module mf3_res_fifo import mf3_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  result_t                    push_data,
	input  logic                       pop,
	output logic                       not_empty,
	output result_t                    head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	result_t         entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign count     = count_q;

endmodule

@@ sv/median_3x3_image_filter_unit.sv @@
// 3x3 median filter over a raster pixel stream, built around one line store memory.
// Depends on mf3_pkg, mf3_if, mf3_line_mem and mf3_res_fifo.
//
// Pixels enter on pix_in in raster order, one word per accepted handshake; frame_start
// marks the pixel at row 0, column 0. For every interior position one result word
// leaves on res_out with the median of its 3x3 neighbourhood, its row and column and
// a mark on the last interior pixel of the frame. Border pixels give no word.
// frame_width and frame_height are written through cfg_we, cfg_index and cfg_data
// while the block is idle; values outside 3 up to the maximum size are clamped.
// One pixel is accepted every cycle while pix_in.ready is high. After the pixel that
// completes its window, its result word passes the line store read, the sort of the
// new column and the median network into the result queue, each step registered.
// After reset the block sweeps the line store to zero, one entry per cycle, so it
// accepts no pixel until every entry is cleared. When the receiver stalls, results
// collect in a four word queue and pix_in.ready falls once the queue and the
// pipeline together hold four words; nothing is lost.
module median_3x3_image_filter_unit import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	mf3_pix_if.sink              pix_in,
	mf3_res_if.source            res_out
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CNW = $clog2(FIFO_DEPTH + 1);
	localparam int OW  = $clog2(FIFO_DEPTH + 3);

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(clamp_size(32'(RESET_WIDTH), 32'(MAX_WIDTH)));
			height_q <= HW'(clamp_size(32'(RESET_HEIGHT), 32'(MAX_HEIGHT)));
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					width_q <= WW'(clamp_size(32'(cfg_data), 32'(MAX_WIDTH)));
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= HW'(clamp_size(32'(cfg_data), 32'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
		end
	end

	logic          clr_q;
	logic [CW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	logic             s1_valid_q;
	logic             s2_valid_q;
	logic [CNW-1:0]   fifo_count;
	logic [OW-1:0]    occupancy;
	logic             in_acc;

	assign occupancy = OW'(fifo_count) + OW'(s1_valid_q) + OW'(s2_valid_q);
	assign pix_in.ready = !clr_q && (occupancy < OW'(FIFO_DEPTH));
	assign in_acc = pix_in.valid && pix_in.ready;

	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_start;
	logic [CW-1:0]    col_start;
	logic [RW-1:0]    row_cur;
	logic [CW-1:0]    col_cur;
	logic [RW-1:0]    row_nxt;
	logic [CW-1:0]    col_nxt;
	logic             row_end;
	logic             emit;
	logic             last_pos;
	logic [31:0]      row_m1;
	logic [31:0]      col_m1;

	always_comb begin
		row_start = pix_in.frame_start ? '0 : row_q;
		col_start = pix_in.frame_start ? '0 : col_q;
		col_cur = (32'(col_start) >= 32'(width_q)) ? '0 : col_start;
		row_cur = (32'(row_start) >= 32'(height_q)) ? '0 : row_start;
		row_end = (32'(col_cur) + 32'd1 >= 32'(width_q));
		col_nxt = row_end ? '0 : col_cur + 1'b1;
		if (row_end) begin
			row_nxt = (32'(row_cur) + 32'd1 >= 32'(height_q)) ? '0 : row_cur + 1'b1;
		end else begin
			row_nxt = row_cur;
		end
		emit = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
		last_pos = (32'(row_cur) == 32'(height_q) - 32'd1)
			&& (32'(col_cur) == 32'(width_q) - 32'd1);
		row_m1 = 32'(row_cur) - 32'd1;
		col_m1 = 32'(col_cur) - 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= row_nxt;
			col_q <= col_nxt;
		end
	end

	logic [CW-1:0]      addr_s1;
	pix_t               px_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [POS_W-1:0]   row_s1;
	logic [POS_W-1:0]   col_s1;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;
	logic [2*PIX_W-1:0] rd_data;
	logic [2*PIX_W-1:0] wr_data;
	pix_t               t_use;
	pix_t               m_use;
	column_t            new_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
		end
	end

	// A pixel that follows at once at the same column must see the entry that the
	// previous pixel writes in this very cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1     <= col_cur;
			px_s1       <= pix_in.pixel;
			emit_s1     <= emit;
			last_s1     <= last_pos;
			row_s1      <= row_m1[POS_W-1:0];
			col_s1      <= col_m1[POS_W-1:0];
			fwd_s1      <= s1_valid_q && (addr_s1 == col_cur);
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		{t_use, m_use} = fwd_s1 ? fwd_data_s1 : rd_data;
		wr_data = {m_use, px_s1};
		new_col = sort3(t_use, m_use, px_s1);
	end

	mf3_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk   (clk),
		.we    (clr_q || s1_valid_q),
		.waddr (clr_q ? clr_addr_q : addr_s1),
		.wdata (clr_q ? '0 : wr_data),
		.raddr (col_cur),
		.rdata (rd_data)
	);

	column_t          win0_q;
	column_t          win1_q;
	column_t          col0_s2;
	column_t          col1_s2;
	column_t          col2_s2;
	logic             last_s2;
	logic [POS_W-1:0] row_s2;
	logic [POS_W-1:0] col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q     <= '0;
			win1_q     <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= s1_valid_q && emit_s1;
			if (s1_valid_q) begin
				win0_q <= win1_q;
				win1_q <= new_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			col0_s2 <= win0_q;
			col1_s2 <= win1_q;
			col2_s2 <= new_col;
			last_s2 <= last_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
		end
	end

	pix_t    max_of_lo;
	pix_t    mid_of_mid;
	pix_t    min_of_hi;
	result_t res_s2;
	result_t fifo_head;
	logic    fifo_not_empty;

	always_comb begin
		max_of_lo  = pix_max(col0_s2.lo, pix_max(col1_s2.lo, col2_s2.lo));
		mid_of_mid = pix_mid3(col0_s2.mid, col1_s2.mid, col2_s2.mid);
		min_of_hi  = pix_min(col0_s2.hi, pix_min(col1_s2.hi, col2_s2.hi));
		res_s2.median_value  = pix_mid3(max_of_lo, mid_of_mid, min_of_hi);
		res_s2.out_row       = row_s2;
		res_s2.out_col       = col_s2;
		res_s2.last_of_frame = last_s2;
	end

	mf3_res_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s2_valid_q),
		.push_data (res_s2),
		.pop       (fifo_not_empty && res_out.ready),
		.not_empty (fifo_not_empty),
		.head      (fifo_head),
		.count     (fifo_count)
	);

	assign res_out.valid         = fifo_not_empty;
	assign res_out.median_value  = fifo_head.median_value;
	assign res_out.out_row       = fifo_head.out_row;
	assign res_out.out_col       = fifo_head.out_col;
	assign res_out.last_of_frame = fifo_head.last_of_frame;

endmodule

@@ sv/mf3_checker.sv @@
// Port-level checks for the median filter, bound to the top level.
// Depends on mf3_pkg and median_3x3_image_filter_unit.
module mf3_checker import mf3_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             res_valid,
	input logic             res_ready,
	input pix_t             res_median,
	input logic [POS_W-1:0] res_row,
	input logic [POS_W-1:0] res_col,
	input logic             res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_median)
			&& $stable(res_row) && $stable(res_col) && $stable(res_last))
		else $error("result word changed while stalled");

	a_no_input_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("pixel accepted before the line store was cleared");

	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_row != '0 && res_col != '0)
		else $error("result word for a border position");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result word without a pixel three cycles earlier");

endmodule

bind median_3x3_image_filter_unit mf3_checker u_mf3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.res_valid  (res_out.valid),
	.res_ready  (res_out.ready),
	.res_median (res_out.median_value),
	.res_row    (res_out.out_row),
	.res_col    (res_out.out_col),
	.res_last   (res_out.last_of_frame)
);
